// ===== rtl/sae_pkg.sv =====
`default_nettype none
package sae_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int HDR_BYTES   = 512;
  localparam int PAD_ALIGN   = 1024;
  localparam int TYPE_AT     = 16;
  localparam int HPOS_W      = $clog2(HDR_BYTES);
  localparam int PAD_W       = $clog2(PAD_ALIGN);
  localparam int LEFT_W      = 33;
  localparam int COUNT_W     = 24;
  localparam int INDEX_W     = 23;
  localparam int WORD_W      = 32;
  localparam int TDATA_W     = 192;

  localparam logic [4:0] MODE_MASK = 5'h1F;
  localparam logic [4:0] MODE_FILE = 5'h17;

  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // tdata bit positions, lowest field first
  localparam int IDX_LSB    = 0;
  localparam int MODE_LSB   = IDX_LSB + INDEX_W;
  localparam int SIZE_LSB   = MODE_LSB + WORD_W;
  localparam int TYPE_LSB   = SIZE_LSB + WORD_W;
  localparam int HOFF_LSB   = TYPE_LSB + WORD_W;
  localparam int DOFF_LSB   = HOFF_LSB + WORD_W;
  localparam int FILE_BIT   = DOFF_LSB + WORD_W;
  localparam int STATUS_BIT = FILE_BIT + 1;
  localparam int PAD_BITS   = TDATA_W - STATUS_BIT - 1;

  typedef struct packed {
    logic                 kind;
    logic                 last;
    logic [INDEX_W-1:0]   entry_index;
    logic [WORD_W-1:0]    entry_mode;
    logic [WORD_W-1:0]    entry_size;
    logic [WORD_W-1:0]    entry_type;
    logic [WORD_W-1:0]    header_offset;
    logic [WORD_W-1:0]    data_offset;
    logic                 is_file;
    logic                 status;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

// ===== rtl/save_archive_entry_parser.sv =====
`default_nettype none
// Save-archive entry parser. Takes the archive one byte per transaction
// (in_tlast on the final byte) and returns, per entry, a record with the
// captured mode, size and type words and the header/data offsets, then one
// status transaction after the final byte. One byte is accepted every
// cycle while in_tready is high; the per-byte work is a single pass of
// counter and capture logic into a 4-deep result queue, and in_tready
// drops only while that queue holds more than two results (a byte that
// completes a header and is also the final byte yields two results).
// Results are written into the queue as the causing byte is accepted.
module save_archive_entry_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,  // [7:0] data_byte
  input  wire logic                       in_tlast,  // last_byte
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [22:0] entry_index, [54:23] entry_mode, [86:55] entry_size,
  // [118:87] entry_type, [150:119] header_offset, [182:151] data_offset,
  // [183] is_file, [184] status, [191:185] zero
  output logic [sae_pkg::TDATA_W-1:0]     out_tdata,
  output logic [0:0]                      out_tuser, // [0] result_kind
  output logic                            out_tlast  // last_result
);
  import sae_pkg::*;

  logic    accept;
  logic    room;
  push_t   push;
  result_t res;

  assign in_tready = room;
  assign accept    = in_tvalid && room;

  sae_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push)
  );

  sae_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {{PAD_BITS{1'b0}}, res.status, res.is_file, res.data_offset,
                      res.header_offset, res.entry_type, res.entry_size,
                      res.entry_mode, res.entry_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
`default_nettype wire

// ===== rtl/sae_parser.sv =====
`default_nettype none
module sae_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output sae_pkg::push_t     push
);
  import sae_pkg::*;

  logic [HPOS_W-1:0]      hpos_r,   hpos_nxt;
  logic                   inpay_r,  inpay_nxt;
  logic [LEFT_W-1:0]      left_r,   left_nxt;
  logic [OFFSET_BITS-1:0] off_r,    off_nxt;
  logic [WORD_W-1:0]      mode_r,   mode_nxt;
  logic [WORD_W-1:0]      size_r,   size_nxt;
  logic [WORD_W-1:0]      type_r,   type_nxt;
  logic [COUNT_W-1:0]     count_r,  count_nxt;

  logic [OFFSET_BITS-1:0]        hoff;
  logic [OFFSET_BITS-1:0]        doff;
  logic [OFFSET_BITS+WORD_W-1:0] hoff_ext;
  logic [OFFSET_BITS+WORD_W-1:0] doff_ext;
  logic                          file;
  logic                          bad;
  result_t                       entry_res;
  result_t                       stat_res;
  logic                          hdr_done;

  always_comb begin
    hoff     = off_r - OFFSET_BITS'(HDR_BYTES - 1);
    doff     = hoff + OFFSET_BITS'(HDR_BYTES);
    hoff_ext = {{WORD_W{1'b0}}, hoff};
    doff_ext = {{WORD_W{1'b0}}, doff};
    file     = (size_r != '0) && ((mode_r[4:0] & MODE_MASK) == MODE_FILE);
    hdr_done = !inpay_r && (hpos_r == HPOS_W'(HDR_BYTES - 1));

    entry_res               = '0;
    entry_res.kind          = KIND_ENTRY;
    entry_res.entry_index   = count_r[INDEX_W-1:0];
    entry_res.entry_mode    = mode_r;
    entry_res.entry_size    = size_r;
    entry_res.entry_type    = type_r;
    entry_res.header_offset = hoff_ext[WORD_W-1:0];
    entry_res.data_offset   = doff_ext[WORD_W-1:0];
    entry_res.is_file       = file;
    entry_res.status        = STATUS_OK;

    hpos_nxt  = hpos_r;
    inpay_nxt = inpay_r;
    left_nxt  = left_r;
    mode_nxt  = mode_r;
    size_nxt  = size_r;
    type_nxt  = type_r;
    count_nxt = count_r;
    off_nxt   = off_r + OFFSET_BITS'(1);

    if (inpay_r) begin
      if (left_r != '0) begin
        left_nxt = left_r - LEFT_W'(1);
      end
      if (left_nxt == '0) begin
        inpay_nxt = 1'b0;
      end
    end else begin
      if (hpos_r[HPOS_W-1:2] == '0) begin
        mode_nxt[8*hpos_r[1:0] +: 8] = data_byte;
      end else if (hpos_r[HPOS_W-1:2] == (HPOS_W-2)'(1)) begin
        size_nxt[8*hpos_r[1:0] +: 8] = data_byte;
      end else if (hpos_r[HPOS_W-1:2] == (HPOS_W-2)'(TYPE_AT / 4)) begin
        type_nxt[8*hpos_r[1:0] +: 8] = data_byte;
      end
      if (hdr_done) begin
        hpos_nxt = '0;
        if (count_r != '1) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        if (file) begin
          left_nxt  = ({1'b0, size_r} + LEFT_W'(PAD_ALIGN - 1)) &
                      ~LEFT_W'(PAD_ALIGN - 1);
          inpay_nxt = 1'b1;
        end
      end else begin
        hpos_nxt = hpos_r + HPOS_W'(1);
      end
    end

    bad             = (inpay_nxt && (left_nxt != '0)) || (count_nxt == '0);
    stat_res        = '0;
    stat_res.kind   = KIND_STATUS;
    stat_res.status = bad ? STATUS_BAD : STATUS_OK;
    stat_res.last   = 1'b1;

    push = '0;
    if (accept) begin
      if (hdr_done) begin
        push.r0 = entry_res;
        if (last_byte) begin
          push.n  = 2'd2;
          push.r1 = stat_res;
        end else begin
          push.n       = 2'd1;
          push.r0.last = 1'b1;
        end
      end else if (last_byte) begin
        push.n  = 2'd1;
        push.r0 = stat_res;
      end
    end

    if (last_byte) begin
      hpos_nxt  = '0;
      inpay_nxt = 1'b0;
      left_nxt  = '0;
      off_nxt   = '0;
      mode_nxt  = '0;
      size_nxt  = '0;
      type_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpos_r  <= '0;
      inpay_r <= 1'b0;
      left_r  <= '0;
      off_r   <= '0;
      mode_r  <= '0;
      size_r  <= '0;
      type_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      hpos_r  <= hpos_nxt;
      inpay_r <= inpay_nxt;
      left_r  <= left_nxt;
      off_r   <= off_nxt;
      mode_r  <= mode_nxt;
      size_r  <= size_nxt;
      type_r  <= type_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sae_out_fifo.sv =====
`default_nettype none
module sae_out_fifo (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sae_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sae_pkg::result_t out_res
);
  import sae_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_r];
  assign room      = (cnt_r <= (PTR_W+1)'(DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.n);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + (PTR_W+1)'(push.n) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_r + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sae_checker.sv =====
`default_nettype none
module sae_checker (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [sae_pkg::TDATA_W-1:0] out_tdata,
  input  wire logic [0:0]             out_tuser,
  input  wire logic                   out_tlast
);
  import sae_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_STATUS) |-> out_tlast)
    else $error("status result not marked last");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_STATUS) |-> (out_tdata[FILE_BIT:0] == '0))
    else $error("status result carries entry fields");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_ENTRY) |-> (out_tdata[STATUS_BIT] == STATUS_OK))
    else $error("entry record carries a status");

endmodule

bind save_archive_entry_parser sae_checker u_sae_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== tb/save_archive_entry_parser_checker.sv =====
`default_nettype none
module save_archive_entry_parser_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic [7:0]                    in_tdata,  // [7:0] data_byte
  input  wire logic                          in_tlast,  // last_byte
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [sae_pkg::TDATA_W-1:0]   out_tdata, // packed record fields
  input  wire logic [0:0]                    out_tuser, // [0] result_kind
  input  wire logic                          out_tlast, // last_result
  output int                                 n_errors,
  output int                                 n_pending,
  output int                                 n_predicted,
  output int                                 n_checked
);
  import sae_pkg::*;

  logic [HPOS_W-1:0]      hdr_pos;
  logic                   skipping;
  logic [LEFT_W-1:0]      skip_left;
  logic [OFFSET_BITS-1:0] byte_off;
  logic [WORD_W-1:0]      mode_w;
  logic [WORD_W-1:0]      size_w;
  logic [WORD_W-1:0]      type_w;
  logic [COUNT_W-1:0]     n_entries;
  result_t                record_q[$];

  task automatic restart_archive();
    hdr_pos   = '0;
    skipping  = 1'b0;
    skip_left = '0;
    byte_off  = '0;
    mode_w    = '0;
    size_w    = '0;
    type_w    = '0;
    n_entries = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic final_byte);
    result_t                rec;
    result_t                stat;
    logic                   got_rec;
    logic                   file;
    logic [OFFSET_BITS-1:0] hoff;
    int                     pos;
    rec     = '0;
    stat    = '0;
    got_rec = 1'b0;
    if (skipping) begin
      if (skip_left != 0) skip_left = skip_left - 1'b1;
      if (skip_left == 0) skipping = 1'b0;
    end else begin
      pos = hdr_pos;
      if (pos < 4) mode_w[8*pos +: 8] = b;
      else if (pos < 8) size_w[8*(pos-4) +: 8] = b;
      else if (pos >= TYPE_AT && pos < TYPE_AT + 4) type_w[8*(pos-TYPE_AT) +: 8] = b;
      if (pos == HDR_BYTES - 1) begin
        hoff = byte_off - OFFSET_BITS'(HDR_BYTES - 1);
        file = (size_w != 0) && (mode_w[4:0] == MODE_FILE);
        rec.kind          = KIND_ENTRY;
        rec.entry_index   = n_entries[INDEX_W-1:0];
        rec.entry_mode    = mode_w;
        rec.entry_size    = size_w;
        rec.entry_type    = type_w;
        rec.header_offset = WORD_W'(hoff);
        rec.data_offset   = WORD_W'(hoff + OFFSET_BITS'(HDR_BYTES));
        rec.is_file       = file;
        rec.status        = STATUS_OK;
        got_rec = 1'b1;
        if (n_entries != '1) n_entries = n_entries + 1'b1;
        hdr_pos = '0;
        if (file) begin
          skip_left = (LEFT_W'(size_w) + LEFT_W'(PAD_ALIGN - 1)) & ~LEFT_W'(PAD_ALIGN - 1);
          skipping  = 1'b1;
        end
      end else begin
        hdr_pos = hdr_pos + 1'b1;
      end
    end
    byte_off = byte_off + 1'b1;
    if (final_byte) begin
      stat.kind   = KIND_STATUS;
      stat.status = ((skipping && skip_left != 0) || n_entries == 0) ? STATUS_BAD : STATUS_OK;
      stat.last   = 1'b1;
      restart_archive();
    end
    if (got_rec) begin
      rec.last = !final_byte;
      record_q.push_back(rec);
      n_predicted++;
    end
    if (final_byte) begin
      record_q.push_back(stat);
      n_predicted++;
    end
  endtask

  task automatic mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    if (n_errors < 10)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    n_errors++;
  endtask

  task automatic compare(input result_t want);
    if (out_tuser[0] != want.kind) mismatch("result_kind", want.kind, out_tuser[0]);
    if (out_tdata[IDX_LSB +: INDEX_W] != want.entry_index)
      mismatch("entry_index", want.entry_index, out_tdata[IDX_LSB +: INDEX_W]);
    if (out_tdata[MODE_LSB +: WORD_W] != want.entry_mode)
      mismatch("entry_mode", want.entry_mode, out_tdata[MODE_LSB +: WORD_W]);
    if (out_tdata[SIZE_LSB +: WORD_W] != want.entry_size)
      mismatch("entry_size", want.entry_size, out_tdata[SIZE_LSB +: WORD_W]);
    if (out_tdata[TYPE_LSB +: WORD_W] != want.entry_type)
      mismatch("entry_type", want.entry_type, out_tdata[TYPE_LSB +: WORD_W]);
    if (out_tdata[HOFF_LSB +: WORD_W] != want.header_offset)
      mismatch("header_offset", want.header_offset, out_tdata[HOFF_LSB +: WORD_W]);
    if (out_tdata[DOFF_LSB +: WORD_W] != want.data_offset)
      mismatch("data_offset", want.data_offset, out_tdata[DOFF_LSB +: WORD_W]);
    if (out_tdata[FILE_BIT] != want.is_file) mismatch("is_file", want.is_file, out_tdata[FILE_BIT]);
    if (out_tdata[STATUS_BIT] != want.status)
      mismatch("status", want.status, out_tdata[STATUS_BIT]);
    if (out_tlast != want.last) mismatch("last_result", want.last, out_tlast);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_archive();
      record_q.delete();
    end else begin
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (record_q.size() == 0) begin
          if (n_errors < 10)
            $display("%0t: unexpected result transaction, kind %0b", $time, out_tuser[0]);
          n_errors++;
        end else begin
          compare(record_q.pop_front());
          n_checked++;
        end
      end
    end
    n_pending = record_q.size();
  end

endmodule
`default_nettype wire

// ===== tb/save_archive_entry_parser_tb.sv =====
`default_nettype none
module save_archive_entry_parser_tb;
  import sae_pkg::*;

  localparam int CLOCK_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  wire logic            in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 in_tlast = 1'b0;
  wire logic            out_tvalid;
  logic                 out_tready = 1'b0;
  wire logic [TDATA_W-1:0] out_tdata;
  wire logic [0:0]      out_tuser;
  wire logic            out_tlast;

  int n_errors;
  int n_pending;
  int n_predicted;
  int n_checked;

  logic       no_idle = 1'b0;
  logic       hold_req = 1'b0;
  int         hold_count = 0;
  int         cycles = 0;
  int         n_bytes = 0;
  int         n_archives = 0;
  logic [7:0] image_q[$];

  save_archive_entry_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  save_archive_entry_parser_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_predicted (n_predicted),
    .n_checked   (n_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CLOCK_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
      $display("** save_archive_entry_parser: FAILED **");
      $finish;
    end
  end

  // receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  function automatic longint padded_len(input logic [31:0] size);
    return ((longint'(size) + PAD_ALIGN - 1) / PAD_ALIGN) * PAD_ALIGN;
  endfunction

  function automatic logic [31:0] pick_mode();
    logic [31:0] m;
    m = $urandom();
    if ($urandom_range(0, 99) < 70) m[4:0] = MODE_FILE;
    return m;
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 25) begin
      case ($urandom_range(0, 3))
        0: return 32'd1;
        1: return 32'd1023;
        2: return 32'd1024;
        default: return 32'd1025;
      endcase
    end
    return $urandom_range(1, 2048);
  endfunction

  task automatic add_fill(input int n);
    repeat (n) image_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_header(input logic [31:0] mode, input logic [31:0] size,
                            input logic [31:0] etype);
    int j;
    for (j = 0; j < HDR_BYTES; j++) begin
      if (j < 4) image_q.push_back(mode[8*j +: 8]);
      else if (j < 8) image_q.push_back(size[8*(j-4) +: 8]);
      else if (j >= TYPE_AT && j < TYPE_AT + 4) image_q.push_back(etype[8*(j-TYPE_AT) +: 8]);
      else image_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_entry();
    logic [31:0] mode;
    logic [31:0] size;
    mode = pick_mode();
    size = pick_size();
    add_header(mode, size, $urandom());
    if (size != 0 && mode[4:0] == MODE_FILE) add_fill(int'(padded_len(size)));
  endtask

  task automatic send_image();
    int i;
    for (i = 0; i < image_q.size(); i++) begin
      while (!no_idle && $urandom_range(0, 99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= image_q[i];
      in_tlast  <= (i == image_q.size() - 1);
      do @(negedge clk); while (!in_tready);
      @(posedge clk);
    end
    n_bytes += image_q.size();
    n_archives++;
    image_q.delete();
  endtask

  task automatic send_random_archive();
    int          r;
    logic [31:0] mode;
    logic [31:0] size;
    longint      cut;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      repeat ($urandom_range(1, 3)) add_entry();
    end else if (r < 77) begin
      // last byte ends a file header or falls inside its payload
      repeat ($urandom_range(0, 2)) add_entry();
      mode = pick_mode();
      mode[4:0] = MODE_FILE;
      size = $urandom_range(0, 1) ? $urandom() : $urandom_range(1, 3000);
      if (size == 0) size = 32'd1;
      add_header(mode, size, $urandom());
      cut = padded_len(size) - 1;
      if (cut > 3000) cut = 3000;
      add_fill($urandom_range(0, int'(cut)));
    end else if (r < 90) begin
      repeat ($urandom_range(1, 3)) add_entry();
      add_fill($urandom_range(1, HDR_BYTES - 1));
    end else begin
      add_fill($urandom_range(1, HDR_BYTES - 1));
    end
    send_image();
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_fill(1);
    send_image();
    add_header('1, '1, '1);
    send_image();
    add_header(32'h17, 32'd0, 32'd0);
    add_header(32'hFFFF_FFF7, 32'd1, 32'h8000_0001);
    add_fill(PAD_ALIGN);
    add_header(32'd0, 32'd0, 32'd0);
    send_image();
    add_header(32'h17, 32'd1024, 32'h5A5A_A5A5);
    add_fill(PAD_ALIGN);
    add_header(32'h0000_8117, 32'd1025, 32'hA5A5_5A5A);
    add_fill(2 * PAD_ALIGN);
    add_fill(1);
    send_image();
    add_header(32'h17, '1, 32'd0);
    add_fill(10);
    send_image();
    add_header(32'h37, 32'd5, 32'd3);
    send_image();
    add_header(32'h16, 32'd5, 32'd2);
    add_fill(HDR_BYTES - 1);
    send_image();

    k = 0;
    while (k < 12 || n_bytes < 800 || n_predicted < 80) begin
      if (k == 3) begin
        // receiver stalls while a burst of one-byte archives keeps coming
        hold_req = 1'b1;
        repeat (12) begin
          add_fill(1);
          send_image();
        end
      end
      no_idle = (k >= 6 && k < 10);
      send_random_archive();
      k++;
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d archives with random gaps and one %0d-cycle output stall.",
             n_bytes, n_archives, HOLD_CYCLES);
    $display("Checked %0d entry records and status results, %0d mismatches.",
             n_checked, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("** save_archive_entry_parser: PASSED **");
    end else begin
      $display("** save_archive_entry_parser: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== save_archive_entry_parser.f =====
rtl/sae_pkg.sv
rtl/sae_parser.sv
rtl/sae_out_fifo.sv
rtl/save_archive_entry_parser.sv
rtl/sae_checker.sv
tb/save_archive_entry_parser_checker.sv
tb/save_archive_entry_parser_tb.sv
